FILE: hw/rtl/ctsh_pkg.sv
// ----------------------------------------------------------------------------
// Crypt-table string hash package
// Constants, state encodings and inter-module structs shared by the hash block.
// ----------------------------------------------------------------------------
package ctsh_pkg;

   // Table geometry: slices of 256 words, five slices produced by the generator
   localparam int unsigned SLICE_WORDS = 256;
   localparam int unsigned GEN_SLICES  = 5;
   localparam int unsigned TABLE_AW    = 11;

   // Running seed start values
   localparam logic [31:0] SEED_ONE_INIT = 32'h7FED_7FED;
   localparam logic [31:0] SEED_TWO_INIT = 32'hEEEE_EEEE;

   // Linear congruential generator used to build the crypt table
   localparam logic [21:0] LCG_START = 22'h10_0001;
   localparam logic [21:0] LCG_MOD   = 22'h2A_AAAB;
   localparam logic [6:0]  LCG_MUL   = 7'd125;
   localparam logic [1:0]  LCG_ADD   = 2'd3;
   localparam logic [15:0] HALF_MASK = 16'hFFFF;

   // Reciprocal of the modulus, scaled by 2^RECIP_SHIFT (floor)
   localparam int unsigned RECIP_SHIFT = 40;
   localparam logic [18:0] LCG_RECIP   = 19'((64'd1 << RECIP_SHIFT) / 64'(LCG_MOD));

   // Last generator position
   localparam logic [2:0] LAST_SLICE = 3'(GEN_SLICES - 1);
   localparam logic [7:0] LAST_ROW   = 8'(SLICE_WORDS - 1);

   // ASCII case folding
   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] LOWER_Z     = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Register index codes (word index on the configuration port)
   localparam logic [0:0] REG_HASH_TYPE = 1'b0;

   // Table build sequencer
   typedef enum logic [1:0] {
      FILL_SCALE,
      FILL_QUOT,
      FILL_REDUCE,
      FILL_DONE
   } fill_state_type;

   // Table write request from the build sequencer
   typedef struct packed {
      logic        we;
      logic [2:0]  slice;
      logic [7:0]  row;
      logic [31:0] data;
   } fill_wr_type;

   // Item stage status from the hash core
   typedef struct packed {
      logic p1_valid;
      logic p1_last;
      logic ready;
   } core_status_type;

endpackage

FILE: hw/rtl/ctsh_table_fill.sv
// ----------------------------------------------------------------------------
// Crypt table build sequencer
// Steps the LCG through the scale, quotient and reduce states and emits one
// table word every two steps, row by row across the five slices.
// ----------------------------------------------------------------------------
module ctsh_table_fill (
   input  logic                   clock,
   input  logic                   reset,
   output ctsh_pkg::fill_wr_type  fill_wr,
   output logic                   fill_done
);

   ctsh_pkg::fill_state_type state_ff, state_in;
   logic [21:0] seed_ff, seed_in;
   logic [28:0] x_ff, x_in;
   logic [6:0]  q_ff, q_in;
   logic [15:0] hi_ff, hi_in;
   logic        half_ff, half_in;
   logic [7:0]  row_ff, row_in;
   logic [2:0]  slice_ff, slice_in;

   logic [28:0] scale;
   logic [47:0] prod_recip;
   logic [28:0] qm;
   logic [28:0] rem;
   logic [28:0] red;
   logic [21:0] seed_new;
   logic [15:0] half_word;

   // LCG arithmetic: x = s*125+3, q ~ x/M via reciprocal, r = x - q*M corrected
   always_comb begin
      scale      = 29'(seed_ff) * 29'(ctsh_pkg::LCG_MUL) + 29'(ctsh_pkg::LCG_ADD);
      prod_recip = 48'(x_ff) * 48'(ctsh_pkg::LCG_RECIP);
      qm         = 29'(q_ff) * 29'(ctsh_pkg::LCG_MOD);
      rem        = x_ff - qm;
      red        = (rem >= 29'(ctsh_pkg::LCG_MOD)) ? rem - 29'(ctsh_pkg::LCG_MOD) : rem;
      seed_new   = red[21:0];
      half_word  = 16'(seed_new) & ctsh_pkg::HALF_MASK;
   end

   // Next state and table write
   always_comb begin
      state_in = state_ff;
      seed_in  = seed_ff;
      x_in     = x_ff;
      q_in     = q_ff;
      hi_in    = hi_ff;
      half_in  = half_ff;
      row_in   = row_ff;
      slice_in = slice_ff;
      fill_wr.we    = 1'b0;
      fill_wr.slice = slice_ff;
      fill_wr.row   = row_ff;
      fill_wr.data  = {hi_ff, half_word};
      case (state_ff)
         ctsh_pkg::FILL_SCALE: begin
            x_in     = scale;
            state_in = ctsh_pkg::FILL_QUOT;
         end
         ctsh_pkg::FILL_QUOT: begin
            q_in     = prod_recip[46:40];
            state_in = ctsh_pkg::FILL_REDUCE;
         end
         ctsh_pkg::FILL_REDUCE: begin
            seed_in  = seed_new;
            state_in = ctsh_pkg::FILL_SCALE;
            if (!half_ff) begin
               hi_in   = half_word;
               half_in = 1'b1;
            end else begin
               fill_wr.we = 1'b1;
               half_in    = 1'b0;
               if (slice_ff == ctsh_pkg::LAST_SLICE) begin
                  slice_in = '0;
                  row_in   = row_ff + 8'd1;
                  if (row_ff == ctsh_pkg::LAST_ROW) begin
                     state_in = ctsh_pkg::FILL_DONE;
                  end
               end else begin
                  slice_in = slice_ff + 3'd1;
               end
            end
         end
         ctsh_pkg::FILL_DONE: begin
            state_in = ctsh_pkg::FILL_DONE;
         end
         default: begin
            state_in = ctsh_pkg::FILL_SCALE;
         end
      endcase
   end

   // Sequencer control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctsh_pkg::FILL_SCALE;
         seed_ff  <= ctsh_pkg::LCG_START;
         half_ff  <= 1'b0;
         row_ff   <= '0;
         slice_ff <= '0;
      end else begin
         state_ff <= state_in;
         seed_ff  <= seed_in;
         half_ff  <= half_in;
         row_ff   <= row_in;
         slice_ff <= slice_in;
      end
   end

   // Arithmetic pipeline registers
   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      q_ff  <= q_in;
      hi_ff <= hi_in;
   end

   assign fill_done = (state_ff == ctsh_pkg::FILL_DONE);

endmodule

FILE: hw/rtl/ctsh_crypt_ram.sv
// ----------------------------------------------------------------------------
// Crypt table memory
// One write port for the build sequencer, one registered read port.
// ----------------------------------------------------------------------------
module ctsh_crypt_ram #(
   parameter int unsigned DEPTH  = 1280,
   parameter int unsigned ADDR_W = 11
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [31:0]       wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [31:0]       rdata
);

   logic [31:0] crypt_mem [DEPTH];
   logic [31:0] rdata_ff;

   // Write from the builder
   always_ff @(posedge clock) begin
      if (we) begin
         crypt_mem[waddr] <= wdata;
      end
   end

   // Registered read, held while no new item is taken
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= crypt_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/ctsh_csr.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style slave holding the hash type; out-of-range writes are dropped.
// ----------------------------------------------------------------------------
module ctsh_csr #(
   parameter int unsigned HASH_TYPES = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [2:0]  hash_type
);

   logic [2:0] hash_type_ff, hash_type_in;
   logic       wr_hit;
   logic [2:0] wr_val;

   // Decode the write and keep only supported types
   always_comb begin
      wr_hit       = csr_psel && csr_penable && csr_pwrite
                     && (csr_paddr[2] == ctsh_pkg::REG_HASH_TYPE);
      wr_val       = csr_pwdata[2:0];
      hash_type_in = hash_type_ff;
      if (wr_hit && ({29'b0, wr_val} < 32'(HASH_TYPES))) begin
         hash_type_in = wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_type_ff <= '0;
      end else begin
         hash_type_ff <= hash_type_in;
      end
   end

   // Read back
   always_comb begin
      case (csr_paddr[2])
         ctsh_pkg::REG_HASH_TYPE: csr_prdata = {29'b0, hash_type_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign hash_type  = hash_type_ff;

endmodule

FILE: hw/rtl/ctsh_hash_core.sv
// ----------------------------------------------------------------------------
// Hash core
// Item stage aligned with the table read, seed update and result register.
// ----------------------------------------------------------------------------
module ctsh_hash_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_load,
   input  logic [7:0]                  item_char,
   input  logic                        item_last,
   input  logic [31:0]                 table_word,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [31:0]                 rsp_hash_value,
   output ctsh_pkg::core_status_type   status
);

   logic        p1_valid_ff, p1_valid_in;
   logic [7:0]  p1_char_ff;
   logic        p1_last_ff;
   logic [31:0] seed_one_ff, seed_one_in;
   logic [31:0] seed_two_ff, seed_two_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] hash_ff, hash_in;

   logic [31:0] s1;
   logic [31:0] s2;
   logic        out_free;
   logic        p1_fire;

   // Seed update for the byte in the item stage
   always_comb begin
      s1 = table_word ^ (seed_one_ff + seed_two_ff);
      s2 = 32'(p1_char_ff) + s1 + seed_two_ff + (seed_two_ff << 5)
           + 32'(ctsh_pkg::LCG_ADD);
   end

   // Stage flow: a last byte waits for the result register to free up
   always_comb begin
      out_free    = !rsp_valid_ff || !rsp_stall;
      p1_fire     = p1_valid_ff && (!p1_last_ff || out_free);
      p1_valid_in = item_load ? 1'b1 : (p1_fire ? 1'b0 : p1_valid_ff);

      seed_one_in = seed_one_ff;
      seed_two_in = seed_two_ff;
      if (p1_fire) begin
         if (p1_last_ff) begin
            seed_one_in = ctsh_pkg::SEED_ONE_INIT;
            seed_two_in = ctsh_pkg::SEED_TWO_INIT;
         end else begin
            seed_one_in = s1;
            seed_two_in = s2;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      hash_in      = hash_ff;
      if (p1_fire && p1_last_ff) begin
         rsp_valid_in = 1'b1;
         hash_in      = s1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         seed_one_ff  <= ctsh_pkg::SEED_ONE_INIT;
         seed_two_ff  <= ctsh_pkg::SEED_TWO_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         seed_one_ff  <= seed_one_in;
         seed_two_ff  <= seed_two_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (item_load) begin
         p1_char_ff <= item_char;
         p1_last_ff <= item_last;
      end
      hash_ff <= hash_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hash_value  = hash_ff;
   assign status.p1_valid = p1_valid_ff;
   assign status.p1_last  = p1_last_ff;
   assign status.ready    = !p1_valid_ff || p1_fire;

endmodule

FILE: hw/rtl/crypt_table_string_hash.sv
// ----------------------------------------------------------------------------
// Crypt-table string hash
// Hashes a key one byte per transfer and returns the 32-bit hash after the
// byte marked last.
//
// Usage:
//  - req channel: key_byte with last_byte; a transfer happens when req_valid
//    is high and req_stall is low. Letters a-z are folded to upper case.
//  - rsp channel: one hash_value per key, transferred when rsp_valid is high
//    and rsp_stall is low.
//  - csr port: hash_type at word 0 selects the table slice; writes of
//    unsupported types are dropped. Write it only while the block is idle.
//  - Throughput: one byte per cycle while req_stall is low. The hash is in
//    the result register after the last byte's table read and seed update.
//  - Reset: the crypt table is rebuilt by the LCG sequencer, two generator
//    steps per word; req_stall stays high until it is done.
//  - Receiver stall: the result register holds; bytes of the next key keep
//    flowing until its last byte reaches the item stage, then req_stall rises.
// ----------------------------------------------------------------------------
module crypt_table_string_hash #(
   parameter int unsigned HASH_TYPES = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_key_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned TABLE_DEPTH = HASH_TYPES * ctsh_pkg::SLICE_WORDS;
   localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);

   ctsh_pkg::fill_wr_type      fill_wr;
   ctsh_pkg::core_status_type  core_status;
   logic                       fill_done;
   logic [2:0]                 hash_type;
   logic [7:0]                 key_char;
   logic                       item_load;
   logic                       tbl_we;
   logic [ctsh_pkg::TABLE_AW-1:0] waddr_full;
   logic [ctsh_pkg::TABLE_AW-1:0] raddr_full;
   logic [31:0]                table_word;

   ctsh_csr #(
      .HASH_TYPES (HASH_TYPES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .hash_type   (hash_type)
   );

   ctsh_table_fill u_fill (
      .clock     (clock),
      .reset     (reset),
      .fill_wr   (fill_wr),
      .fill_done (fill_done)
   );

   // Fold case and form table addresses
   always_comb begin
      key_char = (req_key_byte inside {[ctsh_pkg::LOWER_A:ctsh_pkg::LOWER_Z]})
                 ? req_key_byte - ctsh_pkg::CASE_OFFSET : req_key_byte;
      raddr_full = {hash_type, key_char};
      waddr_full = {fill_wr.slice, fill_wr.row};
      tbl_we     = fill_wr.we && (fill_wr.slice < 3'(HASH_TYPES));
      req_stall  = !fill_done || !core_status.ready;
      item_load  = req_valid && !req_stall;
   end

   ctsh_crypt_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (waddr_full[ADDR_W-1:0]),
      .wdata (fill_wr.data),
      .re    (item_load),
      .raddr (raddr_full[ADDR_W-1:0]),
      .rdata (table_word)
   );

   ctsh_hash_core u_core (
      .clock          (clock),
      .reset          (reset),
      .item_load      (item_load),
      .item_char      (key_char),
      .item_last      (req_last_byte),
      .table_word     (table_word),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_hash_value (rsp_hash_value),
      .status         (core_status)
   );

   // The table, once built, stays built
   a_fill_sticky: assert property (@(posedge clock) disable iff (reset)
      fill_done |=> fill_done)
      else $error("table build restarted without reset");

   // No table write after the build has finished
   a_no_late_write: assert property (@(posedge clock) disable iff (reset)
      fill_done |-> !fill_wr.we)
      else $error("table written after build completed");

   // A result only follows a last byte in the item stage
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(core_status.p1_valid && core_status.p1_last))
      else $error("result raised without a last byte");

endmodule

FILE: tb/sv/ctsh_hash_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Crypt-table string hash checker
// Watches the key, hash and register ports of the hash block. It keeps its
// own crypt table, running seeds and hash type, predicts the hash of every
// key and compares each hash transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module ctsh_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_key_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_hash_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   input  logic        run_done,
   output int          pending,
   output int          mismatch_count
);

   localparam int unsigned TYPE_COUNT  = 5;
   localparam int unsigned TABLE_WORDS = ctsh_pkg::SLICE_WORDS * ctsh_pkg::GEN_SLICES;

   logic [31:0] crypt_words [TABLE_WORDS];
   logic [31:0] run_one = ctsh_pkg::SEED_ONE_INIT;
   logic [31:0] run_two = ctsh_pkg::SEED_TWO_INIT;
   logic [2:0]  type_sel = 3'd0;
   logic [31:0] expected_hashes [$];
   int          error_total = 0;
   bit          end_checked = 1'b0;

   // Fill the table row by row, five slices per row, two generator steps a word
   initial begin
      int unsigned lcg;
      logic [31:0] hi_half;
      lcg = ctsh_pkg::LCG_START;
      for (int row = 0; row < ctsh_pkg::SLICE_WORDS; row++) begin
         for (int slice = 0; slice < ctsh_pkg::GEN_SLICES; slice++) begin
            lcg     = (lcg * ctsh_pkg::LCG_MUL + ctsh_pkg::LCG_ADD) % ctsh_pkg::LCG_MOD;
            hi_half = (lcg & ctsh_pkg::HALF_MASK) << 16;
            lcg     = (lcg * ctsh_pkg::LCG_MUL + ctsh_pkg::LCG_ADD) % ctsh_pkg::LCG_MOD;
            crypt_words[slice * ctsh_pkg::SLICE_WORDS + row] =
               hi_half | (lcg & ctsh_pkg::HALF_MASK);
         end
      end
   end

   // Fold one key byte into the running seeds; queue the hash on the last byte
   task automatic absorb_byte(input logic [7:0] raw, input logic is_last);
      logic [7:0]  folded;
      logic [31:0] table_word;
      logic [31:0] mixed;
      folded = raw;
      if (raw >= ctsh_pkg::LOWER_A && raw <= ctsh_pkg::LOWER_Z) begin
         folded = raw - ctsh_pkg::CASE_OFFSET;
      end
      table_word = crypt_words[type_sel * ctsh_pkg::SLICE_WORDS + folded];
      mixed      = table_word ^ (run_one + run_two);
      run_two    = {24'd0, folded} + mixed + run_two + (run_two << 5)
                   + ctsh_pkg::LCG_ADD;
      run_one    = mixed;
      if (is_last) begin
         expected_hashes = {expected_hashes, run_one};
         run_one = ctsh_pkg::SEED_ONE_INIT;
         run_two = ctsh_pkg::SEED_TWO_INIT;
      end
   endtask

   always @(posedge clock) begin
      logic [31:0] oldest;
      if (reset) begin
         run_one  = ctsh_pkg::SEED_ONE_INIT;
         run_two  = ctsh_pkg::SEED_TWO_INIT;
         type_sel = 3'd0;
         expected_hashes.delete();
      end else begin
         // Compare each hash transfer with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_hashes.size() == 0) begin
               $display("%0t: unexpected hash: expected none, got %08h",
                        $time, rsp_hash_value);
               error_total++;
            end else begin
               oldest = expected_hashes.pop_front();
               if (rsp_hash_value !== oldest) begin
                  $display("%0t: hash mismatch: expected %08h, got %08h",
                           $time, oldest, rsp_hash_value);
                  error_total++;
               end
            end
         end
         // Predict with the hash type in force before this edge
         if (req_valid && !req_stall) begin
            absorb_byte(req_key_byte, req_last_byte);
         end
         // Track writes, drop unknown addresses and unsupported types; check reads
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if ((csr_paddr >> 2) == ctsh_pkg::REG_HASH_TYPE &&
                   csr_pwdata[2:0] < TYPE_COUNT) begin
                  type_sel = csr_pwdata[2:0];
               end
            end else if ((csr_paddr >> 2) == ctsh_pkg::REG_HASH_TYPE &&
                         csr_prdata !== {29'd0, type_sel}) begin
               $display("%0t: hash type readback mismatch: expected %08h, got %08h",
                        $time, {29'd0, type_sel}, csr_prdata);
               error_total++;
            end
         end
      end
      // Flag hashes still owed once stimulus has drained
      if (run_done && !end_checked) begin
         end_checked = 1'b1;
         if (expected_hashes.size() != 0) begin
            $display("%0t: hashes never delivered: expected %0d more, got 0",
                     $time, expected_hashes.size());
            error_total += expected_hashes.size();
         end
      end
      pending        <= expected_hashes.size();
      mismatch_count <= error_total;
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Crypt-table string hash testbench
// Sends directed and random keys one byte per transfer through every hash
// type, with random gaps on the key side and random stalls on the hash side,
// and writes the hash type register between keys, including dropped writes.
// ---------------------------------------------------------------------------
module testbench;

   localparam logic [2:0] HASH_TYPE_ADDR = {ctsh_pkg::REG_HASH_TYPE, 2'b00};
   localparam logic [2:0] SPARE_ADDR     = 3'd4;
   localparam int         TOTAL_BYTES    = 1450;
   localparam int         PHASES         = 8;
   localparam int         QUIET_FROM     = TOTAL_BYTES * 85 / 100;
   localparam int         DRAIN_LIMIT    = 2000;
   localparam int         SETTLE_CYCLES  = 4;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_key_byte  = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [31:0] rsp_hash_value;
   logic        csr_psel      = 1'b0;
   logic        csr_penable   = 1'b0;
   logic        csr_pwrite    = 1'b0;
   logic [2:0]  csr_paddr     = 3'd0;
   logic [31:0] csr_pwdata    = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        run_done      = 1'b0;
   int          pending;
   int          mismatch_count;

   int          byte_count = 0;
   int          key_count  = 0;
   int          idle_odds  = 6;
   bit          quiet      = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   crypt_table_string_hash i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_byte   (req_key_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   ctsh_hash_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_byte   (req_key_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .run_done       (run_done),
      .pending        (pending),
      .mismatch_count (mismatch_count)
   );

   // Stall the hash side in short random bursts
   always begin
      @(posedge clock);
      if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Present one key byte, with an optional gap, and hold until it transfers
   task automatic send_byte(input logic [7:0] key_byte, input logic is_last);
      int gap;
      if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_key_byte  <= key_byte;
      req_last_byte <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      byte_count++;
      if (is_last) key_count++;
      if (byte_count >= QUIET_FROM) quiet = 1'b1;
   endtask

   function automatic logic [7:0] pick_key_byte();
      case ($urandom_range(0, 5))
         0, 1: return 8'($urandom_range(ctsh_pkg::LOWER_A, ctsh_pkg::LOWER_Z));
         2:    return 8'($urandom_range(ctsh_pkg::LOWER_A - ctsh_pkg::CASE_OFFSET,
                                        ctsh_pkg::LOWER_Z - ctsh_pkg::CASE_OFFSET));
         3: begin
            case ($urandom_range(0, 7))
               0: return 8'h00;
               1: return 8'hFF;
               2: return ctsh_pkg::LOWER_A - 8'd1;
               3: return ctsh_pkg::LOWER_Z + 8'd1;
               4: return ctsh_pkg::LOWER_A - ctsh_pkg::CASE_OFFSET - 8'd1;
               5: return ctsh_pkg::LOWER_Z - ctsh_pkg::CASE_OFFSET + 8'd1;
               6: return 8'h80;
               default: return 8'h7F;
            endcase
         end
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly short keys, now and then a long one
   task automatic send_random_key();
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
         send_byte(pick_key_byte(), i == len - 1);
      end
   endtask

   // Setup phase, access phase until csr_pready, then back to idle
   task automatic csr_access(input logic is_write, input logic [2:0] addr,
                             input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off until every hash is back and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [71:0] singles;
      logic [47:0] mixed_case;
      int          target;
      int          drain_cycles;
      singles    = {8'h00, 8'hFF, ctsh_pkg::LOWER_A,
                    ctsh_pkg::LOWER_A - ctsh_pkg::CASE_OFFSET, ctsh_pkg::LOWER_Z,
                    ctsh_pkg::LOWER_Z - ctsh_pkg::CASE_OFFSET,
                    ctsh_pkg::LOWER_A - 8'd1, ctsh_pkg::LOWER_Z + 8'd1, 8'h80};
      mixed_case = {"aBz", "ABZ"};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, HASH_TYPE_ADDR, 32'd0);

      // Single-byte keys at the field extremes and around the letter ranges
      for (int i = 0; i < 9; i++) begin
         send_byte(singles[8 * i +: 8], 1'b1);
      end
      // The same key in mixed and upper case
      for (int i = 5; i >= 0; i--) begin
         send_byte(mixed_case[8 * i +: 8], i == 3 || i == 0);
      end

      // Top slice, including its last word
      settle();
      csr_access(1'b1, HASH_TYPE_ADDR, 32'd4);
      csr_access(1'b0, HASH_TYPE_ADDR, 32'd0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte("q", 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte("Q", 1'b1);

      // Random keys under a sequence of register settings
      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: csr_access(1'b1, HASH_TYPE_ADDR, 32'd2);
            1: csr_access(1'b1, HASH_TYPE_ADDR, 32'd7);
            2: csr_access(1'b1, HASH_TYPE_ADDR, ($urandom & ~32'h7) | 32'd1);
            3: csr_access(1'b1, SPARE_ADDR, $urandom);
            4: csr_access(1'b1, HASH_TYPE_ADDR, 32'd0);
            5: begin
               csr_access(1'b1, HASH_TYPE_ADDR, 32'd5);
               csr_access(1'b1, HASH_TYPE_ADDR, 32'd6);
            end
            6: csr_access(1'b1, HASH_TYPE_ADDR, 32'd3);
            default: csr_access(1'b1, HASH_TYPE_ADDR, 32'd4);
         endcase
         csr_access(1'b0, HASH_TYPE_ADDR, 32'd0);
         idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 10);
         target    = TOTAL_BYTES * (p + 1) / PHASES;
         while (byte_count < target) send_random_key();
      end

      // Drain, then check nothing is owed
      req_valid <= 1'b0;
      drain_cycles = 0;
      do begin
         @(posedge clock);
         drain_cycles++;
      end while (pending != 0 && drain_cycles < DRAIN_LIMIT);
      repeat (8) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("run covered %0d key bytes in %0d keys over hash types 0 to 4,",
               byte_count, key_count);
      $display("with dropped register writes and random gaps and stalls on both sides");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Give up well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
